// File: src/tterc_pkg.sv
// ----------------------------------------------------------------------------
// tterc_pkg
// shared types and constants for the three-term recurrence checksum
// ----------------------------------------------------------------------------
package tterc_pkg;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // recurrence constants
   localparam logic [7:0]  FIRST_OFFSET = 8'd7;
   localparam logic [7:0]  ALPHA_MUL    = 8'd17;
   localparam logic [7:0]  BETA_MUL     = 8'd31;
   localparam logic [15:0] MOD_BASE     = 16'hFFFF;
   // 256 * 65535, larger than any subtracted product, keeps the sum positive
   localparam logic [26:0] MOD_BIAS     = 27'd16776960;

   // one classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] alpha;
      logic [7:0] beta;
      logic       first;
      logic       last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/tterc_front.sv
// ----------------------------------------------------------------------------
// tterc_front
// accepts message bytes, tracks position and forms the index coefficients
// ----------------------------------------------------------------------------
module tterc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // data_byte
   input  logic                req_tlast,
   output logic                push_valid,
   output tterc_pkg::item_type push_item,
   input  logic                push_ready
);
   import tterc_pkg::*;

   logic [7:0]  idx_ff;
   logic [7:0]  idx_in;
   logic        first_ff;
   logic        first_in;
   logic [15:0] alpha_full;
   logic [15:0] beta_full;
   logic        accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   // coefficients are the low byte of index times constant
   assign alpha_full = {8'd0, idx_ff} * {8'd0, ALPHA_MUL};
   assign beta_full  = {8'd0, idx_ff} * {8'd0, BETA_MUL};

   always_comb begin
      push_item.data_byte = req_tdata;
      push_item.alpha     = alpha_full[7:0];
      push_item.beta      = beta_full[7:0];
      push_item.first     = first_ff;
      push_item.last      = req_tlast;
   end

   always_comb begin
      idx_in   = idx_ff;
      first_in = first_ff;
      if (accept) begin
         if (req_tlast) begin
            idx_in   = 8'd0;
            first_in = 1'b1;
         end else begin
            idx_in   = idx_ff + 8'd1;
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 8'd0;
         first_ff <= 1'b1;
      end else begin
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

endmodule

// File: src/tterc_queue.sv
// ----------------------------------------------------------------------------
// tterc_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module tterc_queue #(
   parameter int unsigned DEPTH = tterc_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  tterc_pkg::item_type         push_item,
   output logic                        push_ready,
   output logic                        pop_valid,
   output tterc_pkg::item_type         pop_item,
   input  logic                        pop_ready,
   output tterc_pkg::queue_status_type status
);
   import tterc_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   item_type      entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          push_fire;
   logic          pop_fire;

   assign push_ready   = (count_ff != FULL_COUNT);
   assign pop_valid    = (count_ff != '0);
   assign pop_item     = entries_ff[rd_ptr_ff];
   assign push_fire    = push_valid && push_ready;
   assign pop_fire     = pop_valid && pop_ready;
   assign status.full  = !push_ready;
   assign status.empty = !pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(push_fire) - CW'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/tterc_back.sv
// ----------------------------------------------------------------------------
// tterc_back
// runs the recurrence one byte per cycle, a last byte waiting for a free result
// ----------------------------------------------------------------------------
module tterc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  tterc_pkg::item_type pop_item,
   output logic                pop_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata    // checksum
);
   import tterc_pkg::*;

   logic [15:0] newest_ff;
   logic [15:0] newest_in;
   logic [15:0] older_ff;
   logic [15:0] older_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;

   logic        out_free;
   logic        pop_fire;
   logic [8:0]  factor;
   logic [24:0] plus;
   logic [23:0] minus;
   logic [25:0] diff;
   logic        negative;
   logic [26:0] biased;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] term;

   // a final byte waits until the result register can take it
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready = !pop_item.last || out_free;
   assign pop_fire  = pop_valid && pop_ready;

   // d = (b + alpha) * newest - beta * older
   always_comb begin
      factor   = {1'b0, pop_item.data_byte} + {1'b0, pop_item.alpha};
      plus     = {16'd0, factor} * {9'd0, newest_ff};
      minus    = {16'd0, pop_item.beta} * {8'd0, older_ff};
      diff     = {1'b0, plus} - {2'b00, minus};
      negative = diff[25];
      // negative difference wraps as d + 1; bias by a multiple of the base
      biased   = {diff[25], diff} + 27'(negative) + MOD_BIAS;
      // end-around fold mod 65535
      fold1    = {1'b0, biased[15:0]} + {7'd0, biased[25:16]};
      fold2    = fold1[15:0] + {15'd0, fold1[16]};
      term     = (fold2 == MOD_BASE) ? 16'd0 : fold2;
   end

   always_comb begin
      newest_in = newest_ff;
      older_in  = older_ff;
      if (pop_fire) begin
         if (pop_item.first) begin
            newest_in = {8'd0, pop_item.data_byte} + {8'd0, FIRST_OFFSET};
            older_in  = 16'd1;
         end else begin
            newest_in = term;
            older_in  = newest_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop_fire && pop_item.last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = newest_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff    <= 16'd1;
         older_ff     <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         newest_ff    <= newest_in;
         older_ff     <= older_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/three_term_recurrence_checksum.sv
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum
// byte-stream checksum built on a three-term recurrence mod 65535
// ----------------------------------------------------------------------------
// Feed a message one byte per transfer on the req_ stream and mark its final
// byte with req_tlast; one transfer on the rsp_ stream then carries the
// checksum. The first byte of a message seeds the newest term with byte + 7
// and the older term with 1; every later byte at index i forms
// ((byte + 17i mod 256) * newest - (31i mod 256) * older) mod 65535, a
// negative difference first taking one added. The block takes one byte every
// cycle, back to back, across message boundaries, while the queue is not full;
// that figure is set by the back end, which closes the recurrence (two narrow
// multiplies, a subtract and an end-around fold) combinationally, registering
// each new term. rsp_tvalid rises once the last byte has passed through the
// queue and the result register has loaded its checksum. While a checksum
// waits on rsp_tready, bytes of the next message keep flowing until a further
// final byte or a full queue stalls req_tready. There is no configuration and
// no start-up pass after reset.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum #(
   parameter int unsigned QUEUE_DEPTH = tterc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   // checksum stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [15:0] checksum
);
   import tterc_pkg::*;

   // front to queue
   logic             push_valid;
   item_type         push_item;
   logic             push_ready;
   // queue to back
   logic             pop_valid;
   item_type         pop_item;
   logic             pop_ready;
   queue_status_type queue_status;

   // front: counts bytes in the message, tags first and last, forms
   // the index coefficients
   tterc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // short queue lets the front run on while the result waits
   tterc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .status     (queue_status)
   );

   // back: the recurrence itself and the result register
   tterc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // queue cannot be full and empty at once
   assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty together");

   // a final byte leaves the queue only when the result register is free
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_item.last) |-> (!rsp_tvalid || rsp_tready))
      else $error("final byte consumed over a pending checksum");

   // a one-byte message yields byte + 7
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_item.first && pop_item.last) |=>
      (rsp_tvalid && (rsp_tdata == ({8'd0, $past(pop_item.data_byte)} + 16'd7))))
      else $error("one-byte message checksum wrong");

endmodule
